// ===== rtl/core/sbf_pkg.sv =====
package sbf_pkg;

	localparam int ANALOG_CHANNELS = 16;
	localparam int CHANNEL_BITS    = 11;

	localparam int BYTE_W  = 8;
	localparam int POS_W   = 5;
	localparam int ACC_W   = 18;
	localparam int HELD_W  = 5;
	localparam int CHIDX_W = 5;
	localparam int US_W    = 11;
	localparam int STAT_W  = 2;

	localparam logic [POS_W-1:0] POS_FIRST_DATA = 5'd1;
	localparam logic [POS_W-1:0] POS_LAST_DATA  = 5'd22;
	localparam logic [POS_W-1:0] POS_DIGITAL    = 5'd23;
	localparam logic [POS_W-1:0] POS_IDLE       = 5'd25;

	localparam logic [HELD_W-1:0] HELD_MAX = HELD_W'(CHANNEL_BITS - 1);

	localparam logic [CHIDX_W-1:0] CH_DIGITAL_0 = 5'd16;
	localparam logic [CHIDX_W-1:0] CH_DIGITAL_1 = 5'd17;

	localparam logic [US_W-1:0] US_MIN     = 11'd1000;
	localparam logic [US_W-1:0] US_MAX     = 11'd2000;
	localparam logic [US_W-1:0] RAW_OFFSET = 11'd192;

	localparam logic [STAT_W-1:0] LINK_OK       = 2'd0;
	localparam logic [STAT_W-1:0] LINK_LOST     = 2'd1;
	localparam logic [STAT_W-1:0] LINK_FAILSAFE = 2'd2;

	typedef struct packed {
		logic [CHIDX_W-1:0] channel_index;
		logic [US_W-1:0]    pulse_us;
		logic [STAT_W-1:0]  link_status;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	// floor((raw - 192) * 5 / 8) + 1000, clamped to 1000..2000
	function automatic logic [US_W-1:0] scale_to_us(input logic [CHANNEL_BITS-1:0] raw);
		logic [US_W-1:0] d;
		logic [US_W+2:0] d5;
		logic [US_W+1:0] us;
		d  = raw - RAW_OFFSET;
		d5 = {3'b000, d} + {1'b0, d, 2'b00};
		us = {2'b00, US_MIN} + {2'b00, d5[US_W+2:3]};
		if (raw <= RAW_OFFSET) begin
			return US_MIN;
		end else if (us > {2'b00, US_MAX}) begin
			return US_MAX;
		end else begin
			return us[US_W-1:0];
		end
	endfunction

endpackage

// ===== rtl/core/sbf_decode.sv =====
module sbf_decode
	import sbf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [BYTE_W-1:0] byte_in,
	input  logic              start_in,
	output push_t             push
);

	logic [POS_W-1:0]   pos_q;
	logic [ACC_W-1:0]   acc_q;
	logic [HELD_W-1:0]  held_q;
	logic [CHIDX_W-1:0] nch_q;

	logic [POS_W-1:0]   pos, pos_n;
	logic [ACC_W-1:0]   acc_base, acc_or, acc_n;
	logic [HELD_W-1:0]  held_base, held_c, held_sum, held_n;
	logic [CHIDX_W-1:0] nch_base, nch_n;
	logic [STAT_W-1:0]  status;

	always_comb begin
		pos       = start_in ? '0 : pos_q;
		acc_base  = start_in ? '0 : acc_q;
		held_base = start_in ? '0 : held_q;
		nch_base  = start_in ? '0 : nch_q;
		pos_n     = (pos < POS_IDLE) ? pos + POS_W'(1) : POS_IDLE;

		held_c   = (held_base > HELD_MAX) ? HELD_MAX : held_base;
		acc_or   = acc_base | (ACC_W'(byte_in) << held_c);
		held_sum = held_c + HELD_W'(BYTE_W);

		if (byte_in[3]) begin
			status = LINK_FAILSAFE;
		end else if (byte_in[2]) begin
			status = LINK_LOST;
		end else begin
			status = LINK_OK;
		end

		acc_n      = acc_base;
		held_n     = held_base;
		nch_n      = nch_base;
		push.count = 2'd0;
		push.r0    = '0;
		push.r1    = '0;

		if (pos >= POS_FIRST_DATA && pos <= POS_LAST_DATA) begin
			if (held_sum >= HELD_W'(CHANNEL_BITS)) begin
				acc_n  = acc_or >> CHANNEL_BITS;
				held_n = held_sum - HELD_W'(CHANNEL_BITS);
				if (nch_base < CHIDX_W'(ANALOG_CHANNELS)) begin
					push.count            = 2'd1;
					push.r0.channel_index = nch_base;
					push.r0.pulse_us      = scale_to_us(acc_or[CHANNEL_BITS-1:0]);
					nch_n                 = nch_base + CHIDX_W'(1);
				end
			end else begin
				acc_n  = acc_or;
				held_n = held_sum;
			end
		end else if (pos == POS_DIGITAL) begin
			push.count            = 2'd2;
			push.r0.channel_index = CH_DIGITAL_0;
			push.r0.pulse_us      = byte_in[0] ? US_MAX : US_MIN;
			push.r0.link_status   = status;
			push.r1.channel_index = CH_DIGITAL_1;
			push.r1.pulse_us      = byte_in[1] ? US_MAX : US_MIN;
			push.r1.link_status   = status;
			push.r1.last          = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			acc_q  <= '0;
			held_q <= '0;
			nch_q  <= '0;
		end else if (en) begin
			pos_q  <= pos_n;
			acc_q  <= acc_n;
			held_q <= held_n;
			nch_q  <= nch_n;
		end
	end

endmodule

// ===== rtl/core/sbf_out_fifo.sv =====
module sbf_out_fifo
	import sbf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_en,
	input  push_t   push,
	output logic    space2,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t head
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	result_t            mem [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [PTR_W:0]     cnt_q;
	logic [1:0]         n_push;
	logic               pop;

	assign n_push    = push_en ? push.count : 2'd0;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign space2    = (cnt_q <= (PTR_W+1)'(DEPTH - 2));
	assign head      = mem[rd_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (n_push == 2'd2) begin
			mem[wr_q + PTR_W'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(n_push);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + (PTR_W+1)'(n_push) - (PTR_W+1)'(pop);
		end
	end

endmodule

// ===== rtl/core/sbus_frame_decoder.sv =====
// SBUS frame decoder. Feed the 25 frame bytes one per transfer, frame_start
// high on the header byte. Each completed 11-bit channel in bytes 1..22 gives
// one transfer with pulse_us = floor((raw-192)*5/8)+1000 clamped to 1000..2000;
// byte 23 gives two transfers (channels 16 and 17, 2000 when set, 1000 when
// clear) carrying the link status, last high on channel 17. Each byte is held in
// an input register, then decoded into the result queue, whose head drives the
// outputs; one byte is taken per cycle as long as a 4-entry result queue has room
// for two results, so throughput is one byte per cycle with out_ready held high.
module sbus_frame_decoder
	import sbf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BYTE_W-1:0]  frame_byte,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CHIDX_W-1:0] channel_index,
	output logic [US_W-1:0]    pulse_us,
	output logic [STAT_W-1:0]  link_status,
	output logic               last
);

	logic              valid_s1;
	logic [BYTE_W-1:0] frame_byte_s1;
	logic              frame_start_s1;
	logic              space2;
	logic              adv;
	push_t             push;
	result_t           head;

	assign adv      = valid_s1 && space2;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			frame_byte_s1  <= frame_byte;
			frame_start_s1 <= frame_start;
		end
	end

	sbf_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.byte_in  (frame_byte_s1),
		.start_in (frame_start_s1),
		.push     (push)
	);

	sbf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (adv),
		.push      (push),
		.space2    (space2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign channel_index = head.channel_index;
	assign pulse_us      = head.pulse_us;
	assign link_status   = head.link_status;
	assign last          = head.last;

endmodule

// ===== tb/sv/sbus_frame_checker.sv =====
`timescale 1ns / 100ps

module sbus_frame_checker
	import sbf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [BYTE_W-1:0]  frame_byte,
	input  logic               frame_start,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [CHIDX_W-1:0] channel_index,
	input  logic [US_W-1:0]    pulse_us,
	input  logic [STAT_W-1:0]  link_status,
	input  logic               last,
	output int                 error_count,
	output int                 pending
);

	result_t expected_q [$];

	logic [POS_W-1:0]   byte_pos = '0;
	logic [ACC_W-1:0]   acc      = '0;
	logic [HELD_W-1:0]  held     = '0;
	logic [CHIDX_W-1:0] chan     = '0;

	int      mismatches = 0;
	result_t got;
	result_t want;

	function automatic logic [US_W-1:0] to_pulse(input logic [CHANNEL_BITS-1:0] raw);
		int t;
		if (int'(raw) <= int'(RAW_OFFSET)) begin
			return US_MIN;
		end
		t = int'(US_MIN) + ((int'(raw) - int'(RAW_OFFSET)) * 5) / 8;
		if (t > int'(US_MAX)) begin
			t = int'(US_MAX);
		end
		return t[US_W-1:0];
	endfunction

	function automatic result_t make_result(input logic [CHIDX_W-1:0] idx,
			input logic [US_W-1:0] us, input logic [STAT_W-1:0] st, input logic lst);
		result_t r;
		r.channel_index = idx;
		r.pulse_us      = us;
		r.link_status   = st;
		r.last          = lst;
		return r;
	endfunction

	task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic s);
		logic [POS_W-1:0]        p;
		logic [CHANNEL_BITS-1:0] raw;
		logic [STAT_W-1:0]       st;
		if (s) begin
			acc  = '0;
			held = '0;
			chan = '0;
			p    = '0;
		end else begin
			p = byte_pos;
		end
		byte_pos = (p < POS_IDLE) ? p + 1'b1 : POS_IDLE;

		if (p >= POS_FIRST_DATA && p <= POS_LAST_DATA) begin
			if (held > HELD_MAX) begin
				held = HELD_MAX;
			end
			acc  = acc | (ACC_W'(b) << held);
			held = held + HELD_W'(8);
			if (held >= HELD_W'(CHANNEL_BITS)) begin
				raw  = acc[CHANNEL_BITS-1:0];
				acc  = acc >> CHANNEL_BITS;
				held = held - HELD_W'(CHANNEL_BITS);
				if (chan < CHIDX_W'(ANALOG_CHANNELS)) begin
					expected_q.push_back(make_result(chan, to_pulse(raw), LINK_OK, 1'b0));
					chan = chan + 1'b1;
				end
			end
		end else if (p == POS_DIGITAL) begin
			if (b[3]) begin
				st = LINK_FAILSAFE;
			end else if (b[2]) begin
				st = LINK_LOST;
			end else begin
				st = LINK_OK;
			end
			expected_q.push_back(make_result(CH_DIGITAL_0, b[0] ? US_MAX : US_MIN, st, 1'b0));
			expected_q.push_back(make_result(CH_DIGITAL_1, b[1] ? US_MAX : US_MIN, st, 1'b1));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos = '0;
			acc      = '0;
			held     = '0;
			chan     = '0;
			expected_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				got = make_result(channel_index, pulse_us, link_status, last);
				if (expected_q.size() == 0) begin
					if (mismatches < 10) begin
						$display("%0t: unexpected transfer ch=%0d us=%0d st=%0d last=%0b",
							$realtime, got.channel_index, got.pulse_us,
							got.link_status, got.last);
					end
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						if (mismatches < 10) begin
							$display("%0t: mismatch exp ch=%0d us=%0d st=%0d last=%0b",
								$realtime, want.channel_index, want.pulse_us,
								want.link_status, want.last);
							$display("          got ch=%0d us=%0d st=%0d last=%0b",
								got.channel_index, got.pulse_us,
								got.link_status, got.last);
						end
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_byte(frame_byte, frame_start);
			end
		end
		error_count <= mismatches;
		pending     <= expected_q.size();
	end

endmodule

// ===== tb/sv/tb_sbus_frame_decoder.sv =====
`timescale 1ns / 100ps

module tb_sbus_frame_decoder;
	import sbf_pkg::*;

	localparam int ITEM_TARGET  = 1050;
	localparam int QUIET_AFTER  = 950;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 20;
	localparam int FRAME_LEN    = 25;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic [BYTE_W-1:0] frame_byte  = '0;
	logic              frame_start = 1'b0;
	logic              out_ready   = 1'b0;

	logic               in_ready;
	logic               out_valid;
	logic [CHIDX_W-1:0] channel_index;
	logic [US_W-1:0]    pulse_us;
	logic [STAT_W-1:0]  link_status;
	logic               last;

	int errors;
	int pending;
	int sent         = 0;
	int stall_cycles = 0;
	bit quiet        = 1'b0;
	bit gaps_on      = 1'b1;

	logic [CHANNEL_BITS-1:0] corner_raws [16];

	always #5 clk = ~clk;

	sbus_frame_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.frame_byte    (frame_byte),
		.frame_start   (frame_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.channel_index (channel_index),
		.pulse_us      (pulse_us),
		.link_status   (link_status),
		.last          (last)
	);

	sbus_frame_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.frame_byte    (frame_byte),
		.frame_start   (frame_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.channel_index (channel_index),
		.pulse_us      (pulse_us),
		.link_status   (link_status),
		.last          (last),
		.error_count   (errors),
		.pending       (pending)
	);

	function automatic logic [CHANNEL_BITS-1:0] random_raw();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return CHANNEL_BITS'(192);
			2: return CHANNEL_BITS'(193);
			3: return '1;
			4: return CHANNEL_BITS'($urandom_range(1785, 1800));
			default: return CHANNEL_BITS'($urandom);
		endcase
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s);
		if (!quiet && gaps_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		frame_byte  <= b;
		frame_start <= s;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic send_frame(input logic [16*CHANNEL_BITS-1:0] bits,
			input logic [BYTE_W-1:0] head, input logic [BYTE_W-1:0] flags,
			input logic [BYTE_W-1:0] foot, input int len);
		logic [BYTE_W-1:0] b;
		for (int k = 0; k < len; k++) begin
			if (k == 0) begin
				b = head;
			end else if (k <= 22) begin
				b = bits[8*(k-1) +: 8];
			end else if (k == 23) begin
				b = flags;
			end else if (k == 24) begin
				b = foot;
			end else begin
				b = BYTE_W'($urandom);
			end
			send_byte(b, k == 0);
		end
	endtask

	// hold the sender off until every predicted result has been transferred
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [16*CHANNEL_BITS-1:0] bits;
		int frames;
		int kind;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray byte before any frame start is taken as a header
		send_byte(8'h5A, 1'b0);

		corner_raws = '{11'd0, 11'd192, 11'd193, 11'd194, 11'd200, 11'd1792, 11'd1793,
			11'd1794, 11'd2047, 11'd1000, 11'd1, 11'd2046, 11'd1024, 11'd992,
			11'd172, 11'd1811};
		for (int i = 0; i < 16; i++) begin
			bits[CHANNEL_BITS*i +: CHANNEL_BITS] = corner_raws[i];
		end
		// failsafe and lost both set, both digital channels on
		send_frame(bits, 8'h0F, 8'h0F, 8'h00, FRAME_LEN);
		drain_results();

		frames = 0;
		while (sent < ITEM_TARGET) begin
			if (sent >= QUIET_AFTER) begin
				quiet = 1'b1;
			end
			gaps_on = 1'($urandom_range(0, 1));
			for (int i = 0; i < 16; i++) begin
				bits[CHANNEL_BITS*i +: CHANNEL_BITS] = random_raw();
			end
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				send_frame(bits, ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom) : 8'h0F,
					BYTE_W'($urandom), BYTE_W'($urandom), FRAME_LEN);
			end else if (kind == 7) begin
				send_frame(bits, 8'h0F, BYTE_W'($urandom), BYTE_W'($urandom),
					$urandom_range(1, FRAME_LEN - 1));
			end else if (kind == 8) begin
				send_frame(bits, 8'h0F, BYTE_W'($urandom), BYTE_W'($urandom),
					$urandom_range(FRAME_LEN + 1, FRAME_LEN + 4));
			end else begin
				repeat ($urandom_range(1, 10)) begin
					send_byte(BYTE_W'($urandom), $urandom_range(0, 7) == 0);
				end
			end
			frames++;
			if (frames % 16 == 0 && !quiet) begin
				drain_results();
			end
		end

		quiet = 1'b1;
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
